FILE: src/m3i_pkg.sv
`timescale 1ns / 1ps

package m3i_pkg;

    // entry format
    localparam int ENTRY_WIDTH = 32;
    localparam int FRAC_BITS   = 16;

    // internal widths
    localparam int MAG_W  = ENTRY_WIDTH;          // entry magnitude, holds 2^(EW-1)
    localparam int PAIR_W = 2 * MAG_W;            // product of two magnitudes
    localparam int DET_W  = 3 * MAG_W;            // triple products and their sums
    localparam int REM_W  = DET_W + 1;            // divider partial remainder
    localparam int QUO_W  = 2 * FRAC_BITS;        // quotient bits when cofactor < det
    localparam int QR_W   = QUO_W + 1;            // rounded quotient
    localparam int CMP_W  = ((QR_W > ENTRY_WIDTH) ? QR_W : ENTRY_WIDTH) + 1;

    // singularity shift register
    localparam int              SHIFT_W     = 6;
    localparam logic [SHIFT_W-1:0] SHIFT_RESET = SHIFT_W'(50);

    // cofactor k = sign * (e[i0]*e[i1] - e[i2]*e[i3]), row-major entry index
    localparam logic [3:0] COF_IDX [0:8][0:3] = '{
        '{4'd4, 4'd8, 4'd7, 4'd5}, '{4'd1, 4'd8, 4'd7, 4'd2}, '{4'd1, 4'd5, 4'd4, 4'd2},
        '{4'd3, 4'd8, 4'd6, 4'd5}, '{4'd0, 4'd8, 4'd6, 4'd2}, '{4'd0, 4'd5, 4'd3, 4'd2},
        '{4'd3, 4'd7, 4'd6, 4'd4}, '{4'd0, 4'd7, 4'd6, 4'd1}, '{4'd0, 4'd4, 4'd3, 4'd1}
    };
    // bit k set: cofactor k is negated
    localparam logic [8:0] COF_FLIP = 9'b010101010;

    typedef logic signed [ENTRY_WIDTH-1:0] entry_t;

    typedef struct packed {
        entry_t a00; entry_t a01; entry_t a02;
        entry_t a10; entry_t a11; entry_t a12;
        entry_t a20; entry_t a21; entry_t a22;
    } m3i_in_t;

    typedef struct packed {
        entry_t b00; entry_t b01; entry_t b02;
        entry_t b10; entry_t b11; entry_t b12;
        entry_t b20; entry_t b21; entry_t b22;
        logic   singular;
        logic   saturated;
    } m3i_out_t;

    // one divider stage: shared divisor, nine lanes of remainder and quotient
    typedef struct packed {
        logic [DET_W-1:0]            det;
        logic [8:0][REM_W-1:0]       rem;
        logic [8:0][QUO_W-1:0]       quo;
    } div_stage_t;

endpackage

FILE: src/m3i_div_pipe.sv
`timescale 1ns / 1ps

module m3i_div_pipe import m3i_pkg::*; (
    input  logic       aclk,
    input  logic       en,
    input  div_stage_t din,
    output div_stage_t dout
);

    div_stage_t stg_reg [0:QUO_W-1];

    // one restoring step on all nine lanes
    function automatic div_stage_t div_step(input div_stage_t x);
        div_stage_t       y;
        logic [REM_W-1:0] r2;
        logic [REM_W-1:0] dz;
        logic             qb;
        y  = x;
        dz = {1'b0, x.det};
        for (int k = 0; k < 9; k++) begin
            r2 = {x.rem[k][REM_W-2:0], 1'b0};
            qb = (r2 >= dz);
            y.rem[k] = qb ? (r2 - dz) : r2;
            y.quo[k] = {x.quo[k][QUO_W-2:0], qb};
        end
        return y;
    endfunction

    // one quotient bit per stage
    always_ff @(posedge aclk) begin
        if (en) begin
            stg_reg[0] <= div_step(din);
        end
    end

    for (genvar s = 1; s < QUO_W; s++) begin : g_stage
        always_ff @(posedge aclk) begin
            if (en) begin
                stg_reg[s] <= div_step(stg_reg[s-1]);
            end
        end
    end

    assign dout = stg_reg[QUO_W-1];

endmodule

FILE: src/matrix3x3_inverse_unit.sv
`timescale 1ns / 1ps
// Channel   Ports                           Beat
// input     s_valid s_ready s_data          one 3x3 matrix, a00..a22
// result    m_valid m_ready m_data          inverse b00..b22, singular, saturated
// config    cfg_wr_en cfg_wr_data           singular_shift, taken at once
//
// One matrix per cycle while the result side is not stalled; 8 front stages for the
// products, determinant and threshold, 32 divider stages at one quotient bit
// each, one output register.
// Synchronous active-low reset clears the valid line and sets shift to 50.
// A stall at the result side holds every stage together; s_ready follows
// m_ready when the output register is full.

module matrix3x3_inverse_unit import m3i_pkg::*; (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    output logic               s_ready,
    input  m3i_in_t            s_data,
    output logic               m_valid,
    input  logic               m_ready,
    output m3i_out_t           m_data,
    input  logic               cfg_wr_en,
    input  logic [SHIFT_W-1:0] cfg_wr_data
);

    localparam int NSTG = 8 + QUO_W;

    typedef struct packed {
        m3i_in_t                 raw;
        logic [8:0][PAIR_W-1:0]  cmag;
        logic [8:0]              cneg;
    } carry_t;

    typedef struct packed {
        m3i_in_t    raw;
        logic [8:0] cneg;
        logic       dneg;
        logic [8:0] big;
        logic       singular;
    } side_t;

    logic               adv;
    logic [SHIFT_W-1:0] shift_reg;
    logic [NSTG-1:0]    vld_reg;
    logic               m_valid_reg;
    m3i_out_t           m_data_reg;
    m3i_out_t           m_data_next;

    entry_t             ent [0:8];
    logic [MAG_W-1:0]   emag1_next [0:8];
    logic [8:0]         eneg1_next;
    m3i_in_t            raw1_reg;
    logic [MAG_W-1:0]   emag1_reg [0:8];
    logic [8:0]         eneg1_reg;

    logic [PAIR_W-1:0]  pmag2_reg [0:8];
    logic [PAIR_W-1:0]  qmag2_reg [0:8];
    logic [8:0]         psgn2_reg;
    logic [8:0]         qsgn2_reg;
    logic [MAG_W-1:0]   colm2_reg [0:2];
    logic [2:0]         coln2_reg;
    m3i_in_t            raw2_reg;

    logic [PAIR_W-1:0]  tlo3_reg [0:5];
    logic [PAIR_W-1:0]  thi3_reg [0:5];
    logic [5:0]         tneg3_reg;
    logic [5:0]         tneg3_next;
    logic [PAIR_W-1:0]  tpair [0:5];
    carry_t             car3_next;

    logic [DET_W-1:0]   tmag4_reg [0:5];
    logic [5:0]         tneg4_reg;

    logic [DET_W-1:0]   mpos [0:5];
    logic [DET_W-1:0]   mneg [0:5];
    logic [DET_W-1:0]   psa5_reg, psb5_reg, nsa5_reg, nsb5_reg;
    logic [DET_W-1:0]   pos6_reg, ngs6_reg;
    logic [DET_W-1:0]   det7_reg, sum7_reg;
    logic               dneg7_reg;
    logic [DET_W-1:0]   det8_reg, thr8_reg;
    logic               dneg8_reg;
    logic [8:0]         big8_reg;

    carry_t             car_reg [0:5];

    div_stage_t         div_in;
    div_stage_t         div_out;
    side_t              side_next;
    side_t              side_reg [0:QUO_W-1];

    entry_t             bval [0:8];
    logic [8:0]         lane_sat;

    assign adv     = !m_valid_reg || m_ready;
    assign s_ready = adv;
    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

    // config register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            shift_reg <= SHIFT_RESET;
        end else if (cfg_wr_en) begin
            shift_reg <= cfg_wr_data;
        end
    end

    // valid line and output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg     <= '0;
            m_valid_reg <= 1'b0;
        end else if (adv) begin
            vld_reg     <= {vld_reg[NSTG-2:0], s_valid};
            m_valid_reg <= vld_reg[NSTG-1];
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            m_data_reg <= m_data_next;
        end
    end

    // stage 1: sign and magnitude of each entry
    assign ent[0] = s_data.a00; assign ent[1] = s_data.a01; assign ent[2] = s_data.a02;
    assign ent[3] = s_data.a10; assign ent[4] = s_data.a11; assign ent[5] = s_data.a12;
    assign ent[6] = s_data.a20; assign ent[7] = s_data.a21; assign ent[8] = s_data.a22;

    always_comb begin
        for (int k = 0; k < 9; k++) begin
            eneg1_next[k] = ent[k][ENTRY_WIDTH-1];
            emag1_next[k] = eneg1_next[k] ? MAG_W'(-ent[k]) : MAG_W'(ent[k]);
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            raw1_reg  <= s_data;
            emag1_reg <= emag1_next;
            eneg1_reg <= eneg1_next;
        end
    end

    // stage 2: the eighteen pair products of the cofactors
    always_ff @(posedge aclk) begin
        if (adv) begin
            for (int k = 0; k < 9; k++) begin
                pmag2_reg[k] <= emag1_reg[COF_IDX[k][0]] * emag1_reg[COF_IDX[k][1]];
                qmag2_reg[k] <= emag1_reg[COF_IDX[k][2]] * emag1_reg[COF_IDX[k][3]];
                psgn2_reg[k] <= eneg1_reg[COF_IDX[k][0]] ^ eneg1_reg[COF_IDX[k][1]];
                qsgn2_reg[k] <= eneg1_reg[COF_IDX[k][2]] ^ eneg1_reg[COF_IDX[k][3]];
            end
            for (int i = 0; i < 3; i++) begin
                colm2_reg[i] <= emag1_reg[3*i];
                coln2_reg[i] <= eneg1_reg[3*i];
            end
            raw2_reg <= raw1_reg;
        end
    end

    // stage 3: cofactors, and column-0 entry times pair as two partial products
    always_comb begin
        logic signed [PAIR_W+1:0] ps;
        logic signed [PAIR_W+1:0] qs;
        logic signed [PAIR_W+1:0] cs;
        car3_next.raw = raw2_reg;
        for (int k = 0; k < 9; k++) begin
            ps = $signed({2'b00, pmag2_reg[k]});
            qs = $signed({2'b00, qmag2_reg[k]});
            if (psgn2_reg[k]) ps = -ps;
            if (qsgn2_reg[k]) qs = -qs;
            cs = COF_FLIP[k] ? (qs - ps) : (ps - qs);
            car3_next.cneg[k] = cs[PAIR_W+1];
            car3_next.cmag[k] = cs[PAIR_W+1] ? PAIR_W'(-cs) : PAIR_W'(cs);
        end
        // ascending-cycle term first, then the term that is subtracted
        for (int i = 0; i < 3; i++) begin
            tpair[2*i]      = COF_FLIP[i] ? qmag2_reg[i] : pmag2_reg[i];
            tpair[2*i+1]    = COF_FLIP[i] ? pmag2_reg[i] : qmag2_reg[i];
            tneg3_next[2*i] = coln2_reg[i] ^ (COF_FLIP[i] ? qsgn2_reg[i] : psgn2_reg[i]);
            tneg3_next[2*i+1] =
                !(coln2_reg[i] ^ (COF_FLIP[i] ? psgn2_reg[i] : qsgn2_reg[i]));
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            for (int t = 0; t < 6; t++) begin
                tlo3_reg[t] <= tpair[t][MAG_W-1:0] * colm2_reg[t/2];
                thi3_reg[t] <= tpair[t][PAIR_W-1:MAG_W] * colm2_reg[t/2];
            end
            tneg3_reg  <= tneg3_next;
            car_reg[0] <= car3_next;
        end
    end

    // stage 4: join partial products into the six determinant terms
    always_ff @(posedge aclk) begin
        if (adv) begin
            for (int t = 0; t < 6; t++) begin
                tmag4_reg[t] <= {thi3_reg[t], {MAG_W{1'b0}}} + DET_W'(tlo3_reg[t]);
            end
            tneg4_reg  <= tneg3_reg;
            car_reg[1] <= car_reg[0];
        end
    end

    // stage 5: partial sums of positive and negative terms
    always_comb begin
        for (int t = 0; t < 6; t++) begin
            mpos[t] = tneg4_reg[t] ? '0 : tmag4_reg[t];
            mneg[t] = tneg4_reg[t] ? tmag4_reg[t] : '0;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            psa5_reg   <= mpos[0] + mpos[1] + mpos[2];
            psb5_reg   <= mpos[3] + mpos[4] + mpos[5];
            nsa5_reg   <= mneg[0] + mneg[1] + mneg[2];
            nsb5_reg   <= mneg[3] + mneg[4] + mneg[5];
            car_reg[2] <= car_reg[1];
        end
    end

    // stage 6: full positive and negative sums
    always_ff @(posedge aclk) begin
        if (adv) begin
            pos6_reg   <= psa5_reg + psb5_reg;
            ngs6_reg   <= nsa5_reg + nsb5_reg;
            car_reg[3] <= car_reg[2];
        end
    end

    // stage 7: determinant sign and magnitude, sum of term magnitudes
    always_ff @(posedge aclk) begin
        if (adv) begin
            if (pos6_reg >= ngs6_reg) begin
                det7_reg  <= pos6_reg - ngs6_reg;
                dneg7_reg <= 1'b0;
            end else begin
                det7_reg  <= ngs6_reg - pos6_reg;
                dneg7_reg <= 1'b1;
            end
            sum7_reg   <= pos6_reg + ngs6_reg;
            car_reg[4] <= car_reg[3];
        end
    end

    // stage 8: singularity threshold; flag cofactors whose quotient overflows
    always_ff @(posedge aclk) begin
        if (adv) begin
            thr8_reg  <= (sum7_reg - DET_W'(1)) >> shift_reg;
            det8_reg  <= det7_reg;
            dneg8_reg <= dneg7_reg;
            for (int k = 0; k < 9; k++) begin
                big8_reg[k] <= (DET_W'(car_reg[4].cmag[k]) >= det7_reg);
            end
            car_reg[5] <= car_reg[4];
        end
    end

    // divider input and side data that travels beside it
    always_comb begin
        div_in.det = det8_reg;
        for (int k = 0; k < 9; k++) begin
            div_in.rem[k] = REM_W'(car_reg[5].cmag[k]);
            div_in.quo[k] = '0;
        end
        side_next.raw      = car_reg[5].raw;
        side_next.cneg     = car_reg[5].cneg;
        side_next.dneg     = dneg8_reg;
        side_next.big      = big8_reg;
        side_next.singular = (det8_reg == '0) || (det8_reg <= thr8_reg);
    end

    m3i_div_pipe u_div (
        .aclk (aclk),
        .en   (adv),
        .din  (div_in),
        .dout (div_out)
    );

    always_ff @(posedge aclk) begin
        if (adv) begin
            side_reg[0] <= side_next;
            for (int s = 1; s < QUO_W; s++) begin
                side_reg[s] <= side_reg[s-1];
            end
        end
    end

    // output: round to nearest, apply sign, clip; a singular matrix passes through as given
    always_comb begin
        logic [REM_W:0]     twice;
        logic [QR_W-1:0]    qr;
        logic [CMP_W-1:0]   qx;
        logic [CMP_W-1:0]   lim;
        logic [CMP_W-1:0]   mag;
        logic [CMP_W-1:0]   sval;
        logic               neg;
        side_t              sd;
        sd = side_reg[QUO_W-1];
        for (int k = 0; k < 9; k++) begin
            twice = {div_out.rem[k], 1'b0};
            qr    = QR_W'(div_out.quo[k]) + QR_W'(twice >= (REM_W+1)'(div_out.det));
            qx    = CMP_W'(qr);
            neg   = (sd.cneg[k] != sd.dneg) && (sd.big[k] || (qr != '0));
            lim   = neg ? (CMP_W'(1) << (ENTRY_WIDTH-1))
                        : ((CMP_W'(1) << (ENTRY_WIDTH-1)) - CMP_W'(1));
            lane_sat[k] = sd.big[k] || (qx > lim);
            mag   = lane_sat[k] ? lim : qx;
            sval  = neg ? (-mag) : mag;
            bval[k] = entry_t'(sval[ENTRY_WIDTH-1:0]);
        end
        if (sd.singular) begin
            m_data_next.b00 = sd.raw.a00; m_data_next.b01 = sd.raw.a01;
            m_data_next.b02 = sd.raw.a02; m_data_next.b10 = sd.raw.a10;
            m_data_next.b11 = sd.raw.a11; m_data_next.b12 = sd.raw.a12;
            m_data_next.b20 = sd.raw.a20; m_data_next.b21 = sd.raw.a21;
            m_data_next.b22 = sd.raw.a22;
            m_data_next.saturated = 1'b0;
        end else begin
            m_data_next.b00 = bval[0]; m_data_next.b01 = bval[1];
            m_data_next.b02 = bval[2]; m_data_next.b10 = bval[3];
            m_data_next.b11 = bval[4]; m_data_next.b12 = bval[5];
            m_data_next.b20 = bval[6]; m_data_next.b21 = bval[7];
            m_data_next.b22 = bval[8];
            m_data_next.saturated = |lane_sat;
        end
        m_data_next.singular = sd.singular;
    end

endmodule

FILE: test/tb_top.sv
`timescale 1ns / 1ps

module tb_top;
    import m3i_pkg::*;

    localparam int LATENCY  = 41;
    localparam int N_RANDOM = 1400;
    localparam int BIGW     = 200;

    typedef logic [BIGW-1:0] wide_t;

    logic               aclk;
    logic               aresetn;
    logic               s_valid;
    logic               s_ready;
    m3i_in_t            s_data;
    logic               m_valid;
    logic               m_ready;
    m3i_out_t           m_data;
    logic               cfg_wr_en;
    logic [SHIFT_W-1:0] cfg_wr_data;

    matrix3x3_inverse_unit DUT (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_valid    (s_valid),
        .s_ready    (s_ready),
        .s_data     (s_data),
        .m_valid    (m_valid),
        .m_ready    (m_ready),
        .m_data     (m_data),
        .cfg_wr_en  (cfg_wr_en),
        .cfg_wr_data(cfg_wr_data)
    );

    // predictor state and scoreboard
    logic [SHIFT_W-1:0] shift_model;
    m3i_in_t            pending_mats[$];
    m3i_out_t           expected_inv[$];
    int                 mismatches;
    int                 beats_in;
    int                 beats_out;
    int                 n_singular;
    int                 n_saturated;
    bit                 src_idle_ok;
    bit                 sink_idle_ok;
    bit                 sink_hold_req;

    initial begin
        aclk = 1'b0;
        forever #6 aclk = ~aclk;
    end

    // magnitude of an entry
    function automatic wide_t entry_mag(entry_t e);
        logic [ENTRY_WIDTH:0] x;
        x = {e[ENTRY_WIDTH-1], e};
        if (e[ENTRY_WIDTH-1])
            x = -x;
        return wide_t'(x);
    endfunction

    // inverse by adjugate, exact arithmetic on wide magnitudes
    function automatic m3i_out_t invert_matrix(m3i_in_t m, logic [SHIFT_W-1:0] sh);
        entry_t   e[9];
        wide_t    mg[9];
        bit       ng[9];
        wide_t    pos, neg_acc, dmag, sum, thr, t, p, q, cmag, num, quo, rem, lim;
        bit       dneg, tneg, pn, qn, cneg, rneg, sing;
        int       ia[3], ib[3];
        m3i_out_t r;
        e = '{m.a00, m.a01, m.a02, m.a10, m.a11, m.a12, m.a20, m.a21, m.a22};
        for (int k = 0; k < 9; k++) begin
            mg[k] = entry_mag(e[k]);
            ng[k] = e[k][ENTRY_WIDTH-1];
        end
        pos = '0;
        neg_acc = '0;
        for (int i = 0; i < 3; i++) begin
            ia = '{i * 3, ((i + 1) % 3) * 3 + 1, ((i + 2) % 3) * 3 + 2};
            ib = '{i * 3, ((i + 2) % 3) * 3 + 1, ((i + 1) % 3) * 3 + 2};
            t = mg[ia[0]] * mg[ia[1]] * mg[ia[2]];
            tneg = ng[ia[0]] ^ ng[ia[1]] ^ ng[ia[2]];
            if (tneg) neg_acc += t; else pos += t;
            t = mg[ib[0]] * mg[ib[1]] * mg[ib[2]];
            tneg = ng[ib[0]] ^ ng[ib[1]] ^ ng[ib[2]];
            if (tneg) pos += t; else neg_acc += t;
        end
        sum  = pos + neg_acc;
        dneg = pos < neg_acc;
        dmag = dneg ? neg_acc - pos : pos - neg_acc;
        sing = (dmag == 0);
        if (!sing) begin
            thr  = (sum - 1) >> sh;
            sing = dmag <= thr;
        end
        r = '0;
        if (sing) begin
            r = {m, 1'b1, 1'b0};
            return r;
        end
        for (int k = 0; k < 9; k++) begin
            p  = mg[COF_IDX[k][0]] * mg[COF_IDX[k][1]];
            pn = ng[COF_IDX[k][0]] ^ ng[COF_IDX[k][1]];
            q  = mg[COF_IDX[k][2]] * mg[COF_IDX[k][3]];
            qn = ~(ng[COF_IDX[k][2]] ^ ng[COF_IDX[k][3]]);
            if (pn == qn) begin
                cmag = p + q;
                cneg = pn;
            end else if (p >= q) begin
                cmag = p - q;
                cneg = pn;
            end else begin
                cmag = q - p;
                cneg = qn;
            end
            cneg ^= COF_FLIP[k];
            num  = cmag << (2 * FRAC_BITS);
            quo  = num / dmag;
            rem  = num % dmag;
            if ((rem << 1) >= dmag)
                quo += 1;
            rneg = (cneg != dneg) && (quo != 0);
            lim  = rneg ? (wide_t'(1) << (ENTRY_WIDTH - 1))
                        : (wide_t'(1) << (ENTRY_WIDTH - 1)) - 1;
            if (quo > lim) begin
                quo = lim;
                r.saturated = 1'b1;
            end
            e[k] = rneg ? entry_t'(-quo[ENTRY_WIDTH-1:0]) : entry_t'(quo[ENTRY_WIDTH-1:0]);
        end
        r.b00 = e[0]; r.b01 = e[1]; r.b02 = e[2];
        r.b10 = e[3]; r.b11 = e[4]; r.b12 = e[5];
        r.b20 = e[6]; r.b21 = e[7]; r.b22 = e[8];
        return r;
    endfunction

    function automatic entry_t rand_entry(int mode);
        case (mode)
            0: return entry_t'($urandom);
            1: return entry_t'($urandom_range(0, 8 << FRAC_BITS)) - entry_t'(4 << FRAC_BITS);
            2: return entry_t'($urandom_range(0, 512)) - entry_t'(256);
            default: begin
                case ($urandom_range(0, 5))
                    0: return 32'sh7fffffff;
                    1: return 32'sh80000000;
                    2: return '0;
                    3: return entry_t'(1 << FRAC_BITS);
                    4: return -entry_t'(1 << FRAC_BITS);
                    default: return entry_t'($urandom);
                endcase
            end
        endcase
    endfunction

    function automatic m3i_in_t rand_matrix();
        m3i_in_t m;
        int      mode;
        mode = $urandom_range(0, 9);
        mode = (mode < 2) ? 0 : (mode < 7) ? 1 : (mode < 8) ? 2 : 3;
        m = {rand_entry(mode), rand_entry(mode), rand_entry(mode),
             rand_entry(mode), rand_entry(mode), rand_entry(mode),
             rand_entry(mode), rand_entry(mode), rand_entry(mode)};
        // occasionally make row 2 a copy of row 0 or near it
        if ($urandom_range(0, 15) == 0) begin
            m.a20 = m.a00; m.a21 = m.a01; m.a22 = m.a02 + entry_t'($urandom_range(0, 1));
        end
        return m;
    endfunction

    function automatic m3i_in_t diag(entry_t x, entry_t y, entry_t z);
        m3i_in_t m;
        m = '0;
        m.a00 = x; m.a11 = y; m.a22 = z;
        return m;
    endfunction

    // driver: offers queued matrices, random gaps outside quiet stretch
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else begin
            if (s_valid && s_ready) begin
                expected_inv.push_back(invert_matrix(s_data, shift_model));
                beats_in <= beats_in + 1;
            end
            if (!s_valid || s_ready) begin
                if (pending_mats.size() > 0 &&
                    (!src_idle_ok || $urandom_range(0, 99) >= 10)) begin
                    s_valid <= 1'b1;
                    s_data  <= pending_mats.pop_front();
                end else begin
                    s_valid <= 1'b0;
                end
            end
        end
    end

    // monitor: checks each result beat against oldest expectation
    always @(posedge aclk) begin
        m3i_out_t want;
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else begin
            if (m_valid && m_ready) begin
                beats_out <= beats_out + 1;
                if (expected_inv.size() == 0) begin
                    mismatches <= mismatches + 1;
                    if (mismatches < 10)
                        $display("ERROR: unexpected result beat %h", m_data);
                end else begin
                    want = expected_inv.pop_front();
                    if (want.singular) n_singular <= n_singular + 1;
                    if (want.saturated) n_saturated <= n_saturated + 1;
                    if (m_data !== want) begin
                        mismatches <= mismatches + 1;
                        if (mismatches < 10)
                            $display("ERROR: result %0d exp %h got %h",
                                     beats_out, want, m_data);
                    end
                end
            end
            m_ready <= !sink_hold_req && (!sink_idle_ok || $urandom_range(0, 99) >= 10);
        end
    end

    // long receiver hold-off so the pipeline fills and stalls its input
    initial begin
        sink_hold_req = 1'b0;
        wait (beats_in > 300);
        @(posedge aclk);
        sink_hold_req <= 1'b1;
        for (int c = 0; c < 200; c++)
            @(posedge aclk);
        sink_hold_req <= 1'b0;
    end

    task automatic drain();
        wait (pending_mats.size() == 0 && !s_valid && expected_inv.size() == 0);
        repeat (LATENCY + 5) @(posedge aclk);
    endtask

    task automatic write_shift(logic [SHIFT_W-1:0] v);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= v;
        shift_model  = v;
        @(posedge aclk);
        cfg_wr_en   <= 1'b0;
        @(posedge aclk);
    endtask

    task automatic queue_random(int n);
        for (int i = 0; i < n; i++)
            pending_mats.push_back(rand_matrix());
    endtask

    // stimulus
    initial begin
        m3i_in_t m;
        aresetn      = 1'b0;
        s_valid      = 1'b0;
        s_data       = '0;
        m_ready      = 1'b0;
        cfg_wr_en    = 1'b0;
        cfg_wr_data  = '0;
        mismatches   = 0;
        beats_in     = 0;
        beats_out    = 0;
        n_singular   = 0;
        n_saturated  = 0;
        src_idle_ok  = 1;
        sink_idle_ok = 1;
        shift_model  = SHIFT_RESET;
        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // directed: identity, zero, extremes, scaled, singular, saturating
        pending_mats.push_back(diag(1 << FRAC_BITS, 1 << FRAC_BITS, 1 << FRAC_BITS));
        pending_mats.push_back('0);
        pending_mats.push_back(diag(32'sh7fffffff, 32'sh7fffffff, 32'sh7fffffff));
        pending_mats.push_back(diag(32'sh80000000, 32'sh80000000, 32'sh80000000));
        pending_mats.push_back(diag(1, 1, 1));
        pending_mats.push_back(diag(-1, 2, -3));
        pending_mats.push_back(diag(2 << FRAC_BITS, -(4 << FRAC_BITS), 8 << FRAC_BITS));
        pending_mats.push_back({9{32'sh7fffffff}});
        pending_mats.push_back({9{32'sh80000000}});
        pending_mats.push_back({9{32'shffffffff}});
        m = {32'sh10000, 32'sh20000, 32'sh30000, 32'sh40000, 32'sh50000,
             32'sh60000, 32'sh70000, 32'sh80000, 32'sh90000};
        pending_mats.push_back(m);
        m.a22 = 32'sha0000;
        pending_mats.push_back(m);
        m = {32'sh80000000, 32'sh7fffffff, 32'sh0, 32'sh7fffffff, 32'sh80000000,
             32'sh1, 32'sh0, 32'sh1, 32'sh80000000};
        pending_mats.push_back(m);
        pending_mats.push_back(diag(32'sh7fffffff, 1, 1));
        pending_mats.push_back(diag(32'sh10000, 32'sh10000, 32'sh1));
        drain();

        // sweep the threshold, extremes included
        write_shift(0);
        queue_random(150);
        drain();
        write_shift(63);
        queue_random(150);
        drain();
        write_shift(10);
        queue_random(150);
        drain();
        write_shift(SHIFT_RESET);

        // full-rate stretch without idling on either side
        src_idle_ok  = 0;
        sink_idle_ok = 0;
        queue_random(300);
        drain();
        src_idle_ok  = 1;
        sink_idle_ok = 1;
        queue_random(650);
        drain();

        $display("Checked %0d matrices, %0d judged singular, %0d saturated,",
                 beats_out, n_singular, n_saturated);
        $display("threshold shift swept over 0, 10, 50 and 63 with stalls on both sides.");
        if (mismatches == 0 && expected_inv.size() == 0)
            $display("matrix3x3_inverse_unit verification clean");
        else
            $display("matrix3x3_inverse_unit verification failed");
        $finish;
    end

    // watchdog
    initial begin
        #2000000;
        $display("matrix3x3_inverse_unit verification failed");
        $finish;
    end

endmodule
